### sv/mvt_pkg.sv
// Shared widths, constants and control types for the 4x4 matrix-vector transform.
package mvt_pkg;

    localparam int ROW_COUNT = 4;
    localparam int ELEM_W    = 16;
    localparam int ROW_W     = ROW_COUNT * ELEM_W;
    localparam int FRAC      = 12;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int RND_W     = SUM_W - FRAC;
    localparam int IDX_W     = 8;

    // 1.0 in Q3.12
    localparam logic [ELEM_W-1:0] ONE_Q = ELEM_W'(4096);
    localparam logic [SUM_W-1:0]  RND_HALF = SUM_W'(2048);

    localparam logic signed [ELEM_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [ELEM_W-1:0] SAT_MIN = 16'sh8000;

    // Stage enables for one lane
    typedef struct packed {
        logic en_mul;
        logic en_pair;
        logic en_sum;
    } lane_ctrl_t;

    typedef logic signed [RND_W-1:0] rnd_t;

    // Identity row i: 1.0 on the diagonal
    function automatic logic [ROW_W-1:0] identity_row(input int unsigned i);
        logic [ROW_W-1:0] r;
        r = '0;
        r[i*ELEM_W +: ELEM_W] = ONE_Q;
        return r;
    endfunction

endpackage

### sv/mat4_vector_transform.sv
// Top level of the 4x4 fixed-point matrix-vector transform.
//
// Use: write the matrix rows over the cfg channel (cfg_index 0..3 selects the
// row, cfg_data holds four signed Q3.12 entries, column j in bits 16j+15..16j;
// writes to other indexes are dropped). Write only while no word is in flight.
// Stream vectors in on s_axis; each word gives one result word on m_axis,
// the four row dot products rounded to nearest (ties up) and saturated to
// Q3.12, with m_axis_tuser high if any element was clamped.
// Throughput: one word per cycle while m_axis_tready is high, set by four lanes
// of four multipliers each, one per matrix row, in a pipelined product/add chain.
// Stages: products, pair sums, final sum and rounding, then saturation into the
// output register, each registered between acceptance and m_axis.
// Reset: the matrix returns to the identity, all pipeline words are dropped.
// Stall: each stage holds its word while the one after it is full and
// stalled, so bubbles close up and the input keeps accepting until the
// pipeline is full; nothing is lost when m_axis_tready is low.
module mat4_vector_transform
    import mvt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [ROW_W-1:0]  cfg_data,
    // input vectors
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [ROW_W-1:0]  s_axis_tdata,   // vec_x, vec_y, vec_z, vec_w
    // results
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [ROW_W-1:0]  m_axis_tdata,   // out_x, out_y, out_z, out_w
    output logic [0:0]        m_axis_tuser    // saturated
);

    logic [ROW_W-1:0] row_reg [ROW_COUNT];

    logic       v1_reg, v2_reg, v3_reg;
    logic       v1_next, v2_next, v3_next;
    logic       rdy1, rdy2, rdy3;
    logic       merge_ready;
    lane_ctrl_t ctrl;
    rnd_t       rnd [ROW_COUNT];
    logic       sat;

    // Matrix rows: always ready, ignore indexes past the last row
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROW_COUNT; i++)
            begin
                row_reg[i] <= identity_row(i);
            end
        end
        else if (cfg_valid && (cfg_index < IDX_W'(ROW_COUNT)))
        begin
            row_reg[cfg_index[1:0]] <= cfg_data;
        end
    end

    // A stage may load when it is empty or its word moves on this cycle
    assign rdy3 = !v3_reg || merge_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign s_axis_tready = rdy1;

    always_comb
    begin
        ctrl.en_mul  = s_axis_tvalid && rdy1;
        ctrl.en_pair = v1_reg && rdy2;
        ctrl.en_sum  = v2_reg && rdy3;
    end

    always_comb
    begin
        v1_next = rdy1 ? s_axis_tvalid : v1_reg;
        v2_next = rdy2 ? v1_reg        : v2_reg;
        v3_next = rdy3 ? v2_reg        : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // One lane per matrix row
    for (genvar i = 0; i < ROW_COUNT; i++)
    begin : g_lane
        mvt_lane u_lane
        (
            .clk  (clk),
            .ctrl (ctrl),
            .row  (row_reg[i]),
            .vec  (s_axis_tdata),
            .rnd  (rnd[i])
        );
    end

    mvt_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_ready  (merge_ready),
        .rnd       (rnd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_sat   (sat)
    );

    assign m_axis_tuser = sat;

endmodule

### sv/mvt_lane.sv
// One lane: multiply a matrix row by the vector, add the products and round to Q9.12.
module mvt_lane
    import mvt_pkg::*;
(
    input  logic              clk,
    input  lane_ctrl_t        ctrl,
    input  logic [ROW_W-1:0]  row,
    input  logic [ROW_W-1:0]  vec,
    output rnd_t              rnd
);

    logic signed [PROD_W-1:0] prod_reg  [ROW_COUNT];
    logic signed [PROD_W-1:0] prod_next [ROW_COUNT];
    logic signed [PAIR_W-1:0] pair_reg  [2];
    logic signed [PAIR_W-1:0] pair_next [2];
    logic signed [SUM_W-1:0]  sum;
    rnd_t                     rnd_reg;
    rnd_t                     rnd_next;

    always_comb
    begin
        for (int j = 0; j < ROW_COUNT; j++)
        begin
            prod_next[j] = PROD_W'($signed(row[j*ELEM_W +: ELEM_W]))
                         * PROD_W'($signed(vec[j*ELEM_W +: ELEM_W]));
        end
    end

    always_comb
    begin
        pair_next[0] = PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
        pair_next[1] = PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
    end

    // Exact sum plus half an LSB, then floor by dropping the low FRAC fraction bits
    always_comb
    begin
        sum      = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]) + $signed(RND_HALF);
        rnd_next = sum[SUM_W-1:FRAC];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_mul)
        begin
            for (int j = 0; j < ROW_COUNT; j++)
            begin
                prod_reg[j] <= prod_next[j];
            end
        end
        if (ctrl.en_pair)
        begin
            pair_reg[0] <= pair_next[0];
            pair_reg[1] <= pair_next[1];
        end
        if (ctrl.en_sum)
        begin
            rnd_reg <= rnd_next;
        end
    end

    assign rnd = rnd_reg;

endmodule

### sv/mvt_merge.sv
// Merge stage: saturate the lane results, pack the word and hold it for the receiver.
module mvt_merge
    import mvt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rnd_t              rnd [ROW_COUNT],
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ROW_W-1:0]  out_data,
    output logic              out_sat
);

    localparam rnd_t HI = RND_W'(SAT_MAX);
    localparam rnd_t LO = RND_W'(SAT_MIN);

    logic              valid_reg;
    logic              valid_next;
    logic [ROW_W-1:0]  data_reg;
    logic [ROW_W-1:0]  data_next;
    logic              sat_reg;
    logic              sat_next;
    logic              take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        data_next = '0;
        sat_next  = 1'b0;
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            if (rnd[i] > HI)
            begin
                data_next[i*ELEM_W +: ELEM_W] = SAT_MAX;
                sat_next = 1'b1;
            end
            else if (rnd[i] < LO)
            begin
                data_next[i*ELEM_W +: ELEM_W] = SAT_MIN;
                sat_next = 1'b1;
            end
            else
            begin
                data_next[i*ELEM_W +: ELEM_W] = rnd[i][ELEM_W-1:0];
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
            sat_reg  <= sat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_sat   = sat_reg;

endmodule
